[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks used by the controller unit RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

[src/rtdg_pkg.sv]
// ----------------------------------------------------------------------------
// rtdg_pkg
// Types, constants and the CORDIC step for the go-to-goal controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rtdg_pkg;

  localparam int POS_W  = 32;
  localparam int QUAT_W = 16;
  localparam int LIN_W  = 16;
  localparam int ANG_W  = 16;
  localparam int PH_W   = 3;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;

  localparam int CORDIC_STEPS = 16;
  localparam int CX_W = 45;   // CORDIC x/y datapath
  localparam int CZ_W = 25;   // angle, 2^-20 rad
  localparam int MAG_W = 34;  // operand width before normalizing
  localparam int NORM_MSB = 40;

  // pipeline stage numbers
  localparam int ST_ROT   = 5;
  localparam int ST_ROUND = ST_ROT + CORDIC_STEPS + 1;
  localparam int ST_OUT   = ST_ROUND + 1;

  localparam logic signed [17:0] ANG_PI  = 18'sd12868;
  localparam logic signed [17:0] ANG_2PI = 18'sd25736;
  localparam logic signed [17:0] FINAL_YAW_TOL = 18'sd205;
  localparam logic signed [CZ_W-1:0] HALF_PI_20 = 25'sd1647099;

  localparam logic [20:0] ATAN_TAB [24] = '{
    21'd823550, 21'd486170, 21'd256879, 21'd130396, 21'd65451, 21'd32757,
    21'd16383, 21'd8192, 21'd4096, 21'd2048, 21'd1024, 21'd512,
    21'd256, 21'd128, 21'd64, 21'd32, 21'd16, 21'd8, 21'd4, 21'd2,
    21'd1, 21'd0, 21'd0, 21'd0
  };

  // register indexes
  localparam logic [IDX_W-1:0] REG_ENABLED  = 3'd0;
  localparam logic [IDX_W-1:0] REG_GOAL_X   = 3'd1;
  localparam logic [IDX_W-1:0] REG_GOAL_Y   = 3'd2;
  localparam logic [IDX_W-1:0] REG_GOAL_YAW = 3'd3;
  localparam logic [IDX_W-1:0] REG_LIN_SPD  = 3'd4;
  localparam logic [IDX_W-1:0] REG_ANG_SPD  = 3'd5;
  localparam logic [IDX_W-1:0] REG_DIST_TOL = 3'd6;
  localparam logic [IDX_W-1:0] REG_HEAD_TOL = 3'd7;

  // phase codes
  localparam logic [PH_W-1:0] PH_DISABLED = 3'd0;
  localparam logic [PH_W-1:0] PH_FACE     = 3'd1;
  localparam logic [PH_W-1:0] PH_DRIVE    = 3'd2;
  localparam logic [PH_W-1:0] PH_TURN     = 3'd3;
  localparam logic [PH_W-1:0] PH_ARRIVED  = 3'd4;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
    logic                   zero;
  } cordic_t;

  typedef struct packed {
    logic far;
    logic yaw_ok;
  } side_t;

  // one vectoring micro-rotation, shift s
  function automatic cordic_t cordic_iter(cordic_t c, int unsigned s);
    cordic_t r;
    logic signed [CZ_W-1:0] a;
    r = c;
    a = $signed({4'b0, ATAN_TAB[s]});
    if (c.y > 0) begin
      r.x = c.x + (c.y >>> s);
      r.y = c.y - (c.x >>> s);
      r.z = c.z + a;
    end else begin
      r.x = c.x - (c.y >>> s);
      r.y = c.y + (c.x >>> s);
      r.z = c.z - a;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/rtdg_pose_if.sv]
// ----------------------------------------------------------------------------
// rtdg_pose_if
// Pose request channel: position and orientation quaternion.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtdg_pose_if;
  logic valid;
  logic ready;
  logic signed [rtdg_pkg::POS_W-1:0]  pos_x;
  logic signed [rtdg_pkg::POS_W-1:0]  pos_y;
  logic signed [rtdg_pkg::QUAT_W-1:0] quat_x;
  logic signed [rtdg_pkg::QUAT_W-1:0] quat_y;
  logic signed [rtdg_pkg::QUAT_W-1:0] quat_z;
  logic signed [rtdg_pkg::QUAT_W-1:0] quat_w;

  modport source (output valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                  input ready);
  modport sink (input valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                output ready);
endinterface

`default_nettype wire

[src/rtdg_cmd_if.sv]
// ----------------------------------------------------------------------------
// rtdg_cmd_if
// Velocity command channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtdg_cmd_if;
  logic valid;
  logic ready;
  logic        [rtdg_pkg::LIN_W-1:0] linear_cmd;
  logic signed [rtdg_pkg::ANG_W-1:0] angular_cmd;
  logic        [rtdg_pkg::PH_W-1:0]  phase;

  modport source (output valid, linear_cmd, angular_cmd, phase, input ready);
  modport sink (input valid, linear_cmd, angular_cmd, phase, output ready);
endinterface

`default_nettype wire

[src/rotate_then_drive_goal_controller_unit.sv]
// ----------------------------------------------------------------------------
// rotate_then_drive_goal_controller_unit
// Pipelined rotate-then-drive go-to-goal controller.
// ----------------------------------------------------------------------------
// Usage:
//  - pose: one request per robot pose (position, quaternion); valid/ready.
//  - cmd: one velocity command request per pose, in order; valid/ready.
//  - cfg_write/cfg_index/cfg_data: register writes, only while idle.
// Stages: 23 register stages (5 front stages, one stage per CORDIC step,
// a rounding stage and the output register); cmd valid is the valid bit
// of the output register.
// Throughput: one pose per cycle while cmd is not stalled; the two 16-step CORDIC pipelines (yaw and
// goal bearing) each carry one micro-rotation per stage.
// Stalls: every stage holds its request until the next one is free, so
// bubbles squeeze out and the front keeps accepting while a finished
// command waits; nothing is lost or repeated.
// Reset: clears all stage valid bits and loads register defaults
// (disabled, goal at origin, speed 0.8 m/s, turn 1.0 rad/s).
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rotate_then_drive_goal_controller_unit (
  input  wire logic clk,
  input  wire logic rst,
  rtdg_pose_if.sink pose,
  rtdg_cmd_if.source cmd,
  input  wire logic                           cfg_write,
  input  wire logic [rtdg_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [rtdg_pkg::CFG_W-1:0]     cfg_data
);

  localparam int NS = rtdg_pkg::ST_OUT;
  localparam int CS = rtdg_pkg::CORDIC_STEPS;
  localparam int MW = rtdg_pkg::MAG_W;
  localparam int XW = rtdg_pkg::CX_W;

  // ---------------- configuration registers ----------------
  logic               enabled;
  logic signed [31:0] goal_x, goal_y;
  logic signed [14:0] goal_yaw;
  logic [15:0]        linear_speed;
  logic [14:0]        angular_speed;
  logic [30:0]        distance_tolerance;
  logic [13:0]        heading_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled            <= 1'b0;
      goal_x             <= '0;
      goal_y             <= '0;
      goal_yaw           <= '0;
      linear_speed       <= 16'd3277;
      angular_speed      <= 15'd4096;
      distance_tolerance <= 31'd51;
      heading_tolerance  <= 14'd205;
    end else if (cfg_write) begin
      case (cfg_index)
        rtdg_pkg::REG_ENABLED:  enabled            <= cfg_data[0];
        rtdg_pkg::REG_GOAL_X:   goal_x             <= $signed(cfg_data);
        rtdg_pkg::REG_GOAL_Y:   goal_y             <= $signed(cfg_data);
        rtdg_pkg::REG_GOAL_YAW: goal_yaw           <= $signed(cfg_data[14:0]);
        rtdg_pkg::REG_LIN_SPD:  linear_speed       <= cfg_data[15:0];
        rtdg_pkg::REG_ANG_SPD:  angular_speed      <= cfg_data[14:0];
        rtdg_pkg::REG_DIST_TOL: distance_tolerance <= cfg_data[30:0];
        rtdg_pkg::REG_HEAD_TOL: heading_tolerance  <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  // A stage loads when it is empty or its successor loads.
  logic [NS:1]   vld;
  logic [NS+1:1] rdy;
  logic [NS-1:0] vin;

  // ready ripples back from the output, so walk from the last stage down
  always_comb begin
    rdy[NS+1] = cmd.ready;
    vin[0]    = pose.valid;
    for (int i = NS; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
    for (int i = 1; i < NS; i++) begin
      vin[i] = vld[i];
    end
  end

  assign pose.ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 1; i <= NS; i++) begin
        if (rdy[i]) vld[i] <= vin[i-1];
      end
    end
  end

  // ---------------- stage 1: products, offsets ----------------
  logic signed [31:0] p_wz, p_xy, p_yy, p_zz, p_xz, p_wy;
  logic signed [32:0] s1_dx, s1_dy;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p_wz  <= pose.quat_w * pose.quat_z;
      p_xy  <= pose.quat_x * pose.quat_y;
      p_yy  <= pose.quat_y * pose.quat_y;
      p_zz  <= pose.quat_z * pose.quat_z;
      p_xz  <= pose.quat_x * pose.quat_z;
      p_wy  <= pose.quat_w * pose.quat_y;
      s1_dx <= 33'(goal_x) - 33'(pose.pos_x);
      s1_dy <= 33'(goal_y) - 33'(pose.pos_y);
    end
  end

  // ---------------- stage 2: yaw operands, coarse distance ----------------
  logic signed [MW-1:0] s2_num, s2_den, s2_dx, s2_dy;
  logic                 s2_yaw_ok, s2_far_early;
  logic [32:0]          s2_adx, s2_ady;
  logic signed [32:0]   g_half, adx_c, ady_c;

  always_comb begin
    g_half = 33'(p_xz) - 33'(p_wy);
    adx_c  = (s1_dx < 0) ? -s1_dx : s1_dx;
    ady_c  = (s1_dy < 0) ? -s1_dy : s1_dy;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_num <= (MW'(p_wz) + MW'(p_xy)) <<< 1;
      s2_den <= 34'sh0_4000_0000 - ((MW'(p_yy) + MW'(p_zz)) <<< 1);
      // |2g| < 2^30
      s2_yaw_ok <= (g_half < 33'sh0_2000_0000) && (g_half > -33'sh0_2000_0000);
      s2_dx <= MW'(s1_dx);
      s2_dy <= MW'(s1_dy);
      s2_adx <= adx_c;
      s2_ady <= ady_c;
      s2_far_early <= (adx_c > {2'b0, distance_tolerance})
                   || (ady_c > {2'b0, distance_tolerance});
    end
  end

  // ---------------- stage 3: squares, leading-one search ----------------
  logic [61:0]          s3_sx, s3_sy, s3_tt;
  logic                 s3_far_early, s3_yaw_ok;
  logic signed [MW-1:0] s3_num, s3_den, s3_dx, s3_dy;
  logic [5:0]           s3_ky, s3_kb;
  logic                 s3_zy, s3_zb;
  logic [MW-1:0]        m_y, m_b;
  logic [5:0]           p_y, p_b;

  always_comb begin
    m_y = MW'((s2_num < 0) ? -s2_num : s2_num) | MW'((s2_den < 0) ? -s2_den : s2_den);
    m_b = MW'((s2_dx < 0) ? -s2_dx : s2_dx) | MW'((s2_dy < 0) ? -s2_dy : s2_dy);
    p_y = '0;
    p_b = '0;
    for (int j = 0; j < MW; j++) begin
      if (m_y[j]) p_y = 6'(j);
      if (m_b[j]) p_b = 6'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_sx <= s2_adx[30:0] * s2_adx[30:0];
      s3_sy <= s2_ady[30:0] * s2_ady[30:0];
      s3_tt <= distance_tolerance * distance_tolerance;
      s3_far_early <= s2_far_early;
      s3_yaw_ok <= s2_yaw_ok;
      s3_num <= s2_num;
      s3_den <= s2_den;
      s3_dx  <= s2_dx;
      s3_dy  <= s2_dy;
      s3_ky  <= 6'(rtdg_pkg::NORM_MSB) - p_y;
      s3_kb  <= 6'(rtdg_pkg::NORM_MSB) - p_b;
      s3_zy  <= (m_y == '0);
      s3_zb  <= (m_b == '0);
    end
  end

  // ---------------- stage 4: normalize, fine distance ----------------
  rtdg_pkg::cordic_t s4_yaw, s4_brg;
  rtdg_pkg::side_t   s4_side;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_yaw.x    <= XW'(s3_den) <<< s3_ky;
      s4_yaw.y    <= XW'(s3_num) <<< s3_ky;
      s4_yaw.z    <= '0;
      s4_yaw.zero <= s3_zy;
      s4_brg.x    <= XW'(s3_dx) <<< s3_kb;
      s4_brg.y    <= XW'(s3_dy) <<< s3_kb;
      s4_brg.z    <= '0;
      s4_brg.zero <= s3_zb;
      s4_side.far    <= s3_far_early || ((63'(s3_sx) + 63'(s3_sy)) > 63'(s3_tt));
      s4_side.yaw_ok <= s3_yaw_ok;
    end
  end

  // ---------------- stage 5: rotate into right half-plane ----------------
  function automatic rtdg_pkg::cordic_t pre_rot(rtdg_pkg::cordic_t c);
    rtdg_pkg::cordic_t r;
    r = c;
    if (c.x < 0) begin
      if (c.y >= 0) begin
        r.x = c.y;
        r.y = -c.x;
        r.z = rtdg_pkg::HALF_PI_20;
      end else begin
        r.x = -c.y;
        r.y = c.x;
        r.z = -rtdg_pkg::HALF_PI_20;
      end
    end
    return r;
  endfunction

  rtdg_pkg::cordic_t yaw_c  [0:CS];
  rtdg_pkg::cordic_t brg_c  [0:CS];
  rtdg_pkg::side_t   side_c [0:CS];

  always_ff @(posedge clk) begin
    if (rdy[rtdg_pkg::ST_ROT]) begin
      yaw_c[0]  <= pre_rot(s4_yaw);
      brg_c[0]  <= pre_rot(s4_brg);
      side_c[0] <= s4_side;
    end
  end

  // ---------------- CORDIC stages, one micro-rotation each ----------------
  for (genvar i = 1; i <= CS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rdy[rtdg_pkg::ST_ROT + i]) begin
        yaw_c[i]  <= rtdg_pkg::cordic_iter(yaw_c[i-1], i - 1);
        brg_c[i]  <= rtdg_pkg::cordic_iter(brg_c[i-1], i - 1);
        side_c[i] <= side_c[i-1];
      end
    end
  end

  // ---------------- rounding to 2^-12 rad ----------------
  logic signed [17:0] rnd_yaw, rnd_brg, yaw_q, brg_q;
  logic               far_q;
  logic signed [rtdg_pkg::CZ_W-1:0] zy_r, zb_r;

  always_comb begin
    zy_r = (yaw_c[CS].z + 25'sd128) >>> 8;
    zb_r = (brg_c[CS].z + 25'sd128) >>> 8;
    rnd_yaw = (yaw_c[CS].zero || !side_c[CS].yaw_ok) ? 18'sd0 : zy_r[17:0];
    rnd_brg = brg_c[CS].zero ? 18'sd0 : zb_r[17:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[rtdg_pkg::ST_ROUND]) begin
      yaw_q <= rnd_yaw;
      brg_q <= rnd_brg;
      far_q <= side_c[CS].far;
    end
  end

  // ---------------- decision and output register ----------------
  logic signed [17:0] err_f, err_w, err_n, mag_w, mag_n;
  logic [rtdg_pkg::LIN_W-1:0] lin_next, lin_q;
  logic signed [rtdg_pkg::ANG_W-1:0] ang_pos, ang_next, ang_q;
  logic [rtdg_pkg::PH_W-1:0] ph_next, ph_q;

  always_comb begin
    err_f = brg_q - yaw_q;
    if (err_f > rtdg_pkg::ANG_PI)       err_w = err_f - rtdg_pkg::ANG_2PI;
    else if (err_f < -rtdg_pkg::ANG_PI) err_w = err_f + rtdg_pkg::ANG_2PI;
    else                                err_w = err_f;
    err_n = 18'(goal_yaw) - yaw_q;
    mag_w = (err_w < 0) ? -err_w : err_w;
    mag_n = (err_n < 0) ? -err_n : err_n;
    ang_pos  = $signed({1'b0, angular_speed});
    lin_next = '0;
    ang_next = '0;
    if (!enabled) begin
      ph_next = rtdg_pkg::PH_DISABLED;
    end else if (far_q) begin
      if (mag_w > $signed({4'b0, heading_tolerance})) begin
        ph_next  = rtdg_pkg::PH_FACE;
        ang_next = (err_w > 0) ? ang_pos : -ang_pos;
      end else begin
        ph_next  = rtdg_pkg::PH_DRIVE;
        lin_next = linear_speed;
      end
    end else if (mag_n > rtdg_pkg::FINAL_YAW_TOL) begin
      ph_next  = rtdg_pkg::PH_TURN;
      ang_next = (err_n > 0) ? ang_pos : -ang_pos;
    end else begin
      ph_next = rtdg_pkg::PH_ARRIVED;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS]) begin
      lin_q <= lin_next;
      ang_q <= ang_next;
      ph_q  <= ph_next;
    end
  end

  assign cmd.valid       = vld[NS];
  assign cmd.linear_cmd  = lin_q;
  assign cmd.angular_cmd = ang_q;
  assign cmd.phase       = ph_q;

  // ---------------- checks ----------------
  `ASSERT_NEXT(a_accept_enters, clk, rst, pose.valid && pose.ready, vld[1])
  `ASSERT_NEXT(a_stage1_holds, clk, rst, vld[1] && !rdy[1], vld[1])
  `ASSERT_IMP(a_disabled_zero, clk, rst, cmd.valid && (cmd.phase == rtdg_pkg::PH_DISABLED), (cmd.linear_cmd == '0) && (cmd.angular_cmd == '0))
  `ASSERT_IMP(a_drive_straight, clk, rst, cmd.valid && (cmd.phase == rtdg_pkg::PH_DRIVE), cmd.angular_cmd == '0)

endmodule

`default_nettype wire
